[rtl/hpet_pkg.sv]
// ----------------------------------------------------------------------------
// hpet_pkg
// Shared types and constants of the event timer block.
// ----------------------------------------------------------------------------
package hpet_pkg;

	localparam int MAX_TIMERS = 3;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [1:0] SZ_4 = 2'd2;
	localparam logic [1:0] SZ_8 = 2'd3;

	localparam logic [8:0] OFF_CAP_LO = 9'h000;
	localparam logic [8:0] OFF_CAP_HI = 9'h004;
	localparam logic [8:0] OFF_GEN    = 9'h010;
	localparam logic [8:0] OFF_CNT_LO = 9'h0F0;
	localparam logic [8:0] OFF_CNT_HI = 9'h0F4;
	localparam logic [8:0] OFF_TCFG   = 9'h100;
	localparam logic [8:0] OFF_TCMP   = 9'h108;
	localparam logic [8:0] TMR_STRIDE = 9'h020;

	localparam logic [31:0] CAP_HI = 32'd100000000;
	localparam logic [15:0] VENDOR = 16'h5E14;

	localparam int BIT_EN      = 0;
	localparam int BIT_LEGACY  = 1;
	localparam int BIT_INT_EN  = 2;
	localparam int BIT_PERIOD  = 3;
	localparam int BIT_PER_CAP = 4;
	localparam int BIT_VAL_SET = 6;

	// decoded access, from controller to datapath
	typedef struct packed {
		logic        rd;          // read of a valid register
		logic        err;         // bus error
		logic        wr_gen;
		logic        wr_cnt;
		logic        wr_cfg;
		logic        wr_cmp;
		logic        tick;
		logic        is_tick;     // beat is a tick, held with its result
		logic [1:0]  tmr;
		logic [1:0]  size;
		logic [8:0]  offset;
		logic [63:0] wdata;
	} hpet_cmd_t;

	function automatic logic [63:0] fixed_mask(input logic [1:0] n);
		logic [63:0] m;
		m = '0;
		unique case (n)
			2'd0: begin
				m[BIT_PER_CAP] = 1'b1;
				m[32+13] = 1'b1;
			end
			2'd1: m[32+14] = 1'b1;
			default: m[32+15] = 1'b1;
		endcase
		return m;
	endfunction

	function automatic logic [63:0] width_mask(input logic [1:0] sz);
		unique case (sz)
			2'd0: return 64'h0000_0000_0000_00FF;
			2'd1: return 64'h0000_0000_0000_FFFF;
			2'd2: return 64'h0000_0000_FFFF_FFFF;
			default: return '1;
		endcase
	endfunction

endpackage

[rtl/hpet_timer_block.sv]
// ----------------------------------------------------------------------------
// hpet_timer_block
// Event timer: 32-bit main counter, comparators, register window.
// ----------------------------------------------------------------------------
// channel  dir  tdata (low bit up)                           tuser
// s_axis   in   op[1:0] offset[10:2] size[12:11] wdata[76:13]  -
// m_axis   out  read_data[63:0] bus_error[64] irq_lines[96:65] -
//
// The controller decodes each beat at the input edge and
// the datapath updates its registers at the next edge while the result is
// held in the output stage. A new beat is taken whenever the output stage is
// empty or being drained, so full rate is one beat per cycle.
// Reset loads the timer capability masks and clears everything else.
// A stalled output holds its beat and stops the input.
module hpet_timer_block import hpet_pkg::*; #(
	parameter int NUM_TIMERS = 3
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [79:0]  s_axis_tdata,  // op, offset, access_size, write_data
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata   // read_data, bus_error, irq_lines
);

	hpet_cmd_t   cmd;
	logic [63:0] read_data;
	logic        bus_error;
	logic [31:0] irq_lines;

	hpet_ctrl #(.NUM_TIMERS(NUM_TIMERS)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.op(s_axis_tdata[1:0]), .offset(s_axis_tdata[10:2]),
		.size(s_axis_tdata[12:11]), .wdata(s_axis_tdata[76:13]),
		.cmd(cmd), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready)
	);

	hpet_dp #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.read_data(read_data), .bus_error(bus_error), .irq_lines(irq_lines)
	);

	// results are formed from the held command and the state before it is
	// applied; a tick's pins are computed in its first output cycle and held
	assign m_axis_tdata = {7'd0, irq_lines, bus_error, read_data};

endmodule

[rtl/hpet_ctrl.sv]
// ----------------------------------------------------------------------------
// hpet_ctrl
// Handshake control and access decode; issues one command per beat.
// ----------------------------------------------------------------------------
module hpet_ctrl import hpet_pkg::*; #(
	parameter int NUM_TIMERS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [8:0]  offset,
	input  logic [1:0]  size,
	input  logic [63:0] wdata,
	output hpet_cmd_t   cmd,
	output logic        out_valid,
	input  logic        out_ready
);

	typedef enum logic {ST_EMPTY, ST_FULL} state_t;
	state_t state_q;
	logic   fire;
	logic   wide;
	logic   is_cfg, is_cmp;
	logic [1:0] tcfg, tcmp;

	assign in_ready  = (state_q == ST_EMPTY) || out_ready;
	assign fire      = in_valid && in_ready;
	assign out_valid = (state_q == ST_FULL);
	assign wide      = (size == SZ_4) || (size == SZ_8);

	always_comb begin
		is_cfg = 1'b0;
		is_cmp = 1'b0;
		tcfg = '0;
		tcmp = '0;
		for (int n = 0; n < NUM_TIMERS; n++) begin
			if (offset == OFF_TCFG + 9'(n) * TMR_STRIDE) begin
				is_cfg = 1'b1;
				tcfg = 2'(n);
			end
			if (offset == OFF_TCMP + 9'(n) * TMR_STRIDE) begin
				is_cmp = 1'b1;
				tcmp = 2'(n);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
			cmd <= '0;
		end else begin
			if (fire) state_q <= ST_FULL;
			else if (out_ready) state_q <= ST_EMPTY;
			if (fire) begin
				cmd <= '0;
				cmd.tmr <= is_cfg ? tcfg : tcmp;
				cmd.size <= size;
				cmd.offset <= offset;
				cmd.wdata <= wdata;
				unique case (op)
					OP_READ: begin
						priority if (offset == OFF_CAP_LO || is_cfg || is_cmp) begin
							cmd.rd <= wide;
							cmd.err <= !wide;
						end else if (offset == OFF_CAP_HI) begin
							cmd.rd <= (size == SZ_4);
							cmd.err <= (size != SZ_4);
						end else if (offset == OFF_GEN || offset == OFF_CNT_LO
								|| offset == OFF_CNT_HI) begin
							cmd.rd <= 1'b1;
						end else begin
							cmd.err <= 1'b1;
						end
					end
					OP_WRITE: begin
						priority if (offset == OFF_GEN) begin
							cmd.wr_gen <= wide;
							cmd.err <= !wide;
						end else if (offset == OFF_CNT_LO || offset == OFF_CNT_HI) begin
							cmd.wr_cnt <= 1'b1;
						end else if (is_cfg) begin
							cmd.wr_cfg <= wide;
							cmd.err <= !wide;
						end else if (is_cmp) begin
							cmd.wr_cmp <= 1'b1;
						end else begin
							cmd.err <= 1'b1;
						end
					end
					OP_TICK: begin
						cmd.tick <= 1'b1;
						cmd.is_tick <= 1'b1;
					end
					default: ;
				endcase
			end else begin
				// hold the payload, drop the side effects once applied
				cmd.wr_gen <= 1'b0;
				cmd.wr_cnt <= 1'b0;
				cmd.wr_cfg <= 1'b0;
				cmd.wr_cmp <= 1'b0;
				cmd.tick <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_gen, cmd.wr_cnt, cmd.wr_cfg, cmd.wr_cmp, cmd.tick}))
		else $error("more than one update command");
	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.err |-> !(cmd.rd || cmd.wr_gen || cmd.wr_cfg || cmd.tick))
		else $error("error with side effect");
	a_cmd_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(fire) |-> !cmd.tick)
		else $error("tick repeated");
`endif

endmodule

[rtl/hpet_dp.sv]
// ----------------------------------------------------------------------------
// hpet_dp
// Register file, main counter and comparators; results formed from the command.
// ----------------------------------------------------------------------------
module hpet_dp import hpet_pkg::*; #(
	parameter int NUM_TIMERS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  hpet_cmd_t   cmd,
	output logic [63:0] read_data,
	output logic        bus_error,
	output logic [31:0] irq_lines
);

	logic [63:0] gen_q;
	logic [31:0] cnt_q;
	logic [63:0] tset_q [NUM_TIMERS];
	logic [31:0] cmp_q  [NUM_TIMERS];
	logic [31:0] step_q [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] armed_q;
	logic [31:0] pins_q;

	logic [63:0] cap_w;
	logic [31:0] cnt_n;
	logic        en;
	logic [63:0] rd_raw;
	logic [31:0] pins_c;
	logic [4:0]  pin_c;

	assign en = gen_q[BIT_EN];
	assign cnt_n = cnt_q + 32'd1;

	always_comb begin
		cap_w = {CAP_HI, VENDOR, 1'b1, 7'(NUM_TIMERS - 1), 8'h01};
		rd_raw = '0;
		priority if (cmd.offset == OFF_CAP_LO) rd_raw = cap_w;
		else if (cmd.offset == OFF_CAP_HI) rd_raw = {32'd0, cap_w[63:32]};
		else if (cmd.offset == OFF_GEN) rd_raw = gen_q;
		else if (cmd.offset == OFF_CNT_LO) rd_raw = {32'd0, cnt_q};
		else if (cmd.offset == OFF_CNT_HI) rd_raw = '0;
		else if (cmd.offset[3]) rd_raw = {32'd0, cmp_q[cmd.tmr]};
		else rd_raw = tset_q[cmd.tmr];
	end

	// pins fired by the tick in hand, from the state before it is applied
	always_comb begin
		pins_c = '0;
		pin_c = '0;
		if (cmd.tick && en) begin
			for (int n = 0; n < NUM_TIMERS; n++) begin
				if (armed_q[n] && cmp_q[n] == cnt_n) begin
					pin_c = tset_q[n][13:9];
					if (gen_q[BIT_LEGACY] && n == 0) pin_c = 5'd2;
					if (gen_q[BIT_LEGACY] && n == 1) pin_c = 5'd8;
					if (tset_q[n][BIT_INT_EN]) pins_c[pin_c] = 1'b1;
				end
			end
		end
	end

	assign read_data = cmd.rd ? (rd_raw & width_mask(cmd.size)) : '0;
	assign bus_error = cmd.err;
	// hold the pins of a tick for as long as its beat waits
	assign irq_lines = cmd.is_tick ? (cmd.tick ? pins_c : pins_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		logic [63:0] v;
		logic [63:0] m;
		logic        per;
		if (!arst_n) begin
			gen_q <= '0;
			cnt_q <= '0;
			armed_q <= '0;
			pins_q <= '0;
			for (int n = 0; n < NUM_TIMERS; n++) begin
				tset_q[n] <= fixed_mask(2'(n));
				cmp_q[n] <= '0;
				step_q[n] <= '0;
			end
		end else begin
			if (cmd.wr_gen) begin
				v = (cmd.size == SZ_4) ? {gen_q[63:32], cmd.wdata[31:0]} : cmd.wdata;
				gen_q <= v;
				if (!en && v[BIT_EN]) begin
					// enable edge: zero the counter, rearm against zero
					cnt_q <= '0;
					for (int n = 0; n < NUM_TIMERS; n++) begin
						if (!(tset_q[n][BIT_PERIOD] && step_q[n] == '0) && cmp_q[n] != '0)
							armed_q[n] <= 1'b1;
					end
				end
			end
			if (cmd.wr_cnt && en) cnt_q <= '0;
			if (cmd.wr_cfg) begin
				m = fixed_mask(cmd.tmr);
				v = (cmd.size == SZ_4) ? {tset_q[cmd.tmr][63:32], cmd.wdata[31:0]}
					: cmd.wdata;
				v = {m[63:32], v[31:0]};
				v[BIT_PER_CAP] = m[BIT_PER_CAP];
				if (!m[BIT_PER_CAP]) v[BIT_PERIOD] = 1'b0;
				tset_q[cmd.tmr] <= v;
			end
			if (cmd.wr_cmp) begin
				per = tset_q[cmd.tmr][BIT_PERIOD];
				if (per && !tset_q[cmd.tmr][BIT_VAL_SET]) begin
					step_q[cmd.tmr] <= cmd.wdata[31:0];
				end else begin
					cmp_q[cmd.tmr] <= cmd.wdata[31:0];
					if (!per) step_q[cmd.tmr] <= '0;
					tset_q[cmd.tmr][BIT_VAL_SET] <= 1'b0;
					if (en && !(per && step_q[cmd.tmr] == '0)
							&& cmd.wdata[31:0] != cnt_q)
						armed_q[cmd.tmr] <= 1'b1;
				end
			end
			if (cmd.tick) pins_q <= pins_c;
			if (cmd.tick && en) begin
				cnt_q <= cnt_n;
				for (int n = 0; n < NUM_TIMERS; n++) begin
					if (armed_q[n] && cmp_q[n] == cnt_n) begin
						armed_q[n] <= 1'b0;
						// periodic reload; new compare is never the counter
						if (tset_q[n][BIT_PERIOD] && step_q[n] != '0) begin
							cmp_q[n] <= cnt_n + step_q[n];
							armed_q[n] <= 1'b1;
						end
					end
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_hold_off: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(en) && !$past(cmd.wr_gen) |-> $stable(cnt_q))
		else $error("counter moved while disabled");
	a_pins_tick: assert property (@(posedge clk) disable iff (!arst_n)
		irq_lines != '0 |-> cmd.is_tick)
		else $error("interrupt without tick");
	a_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		tset_q[0][63:32] == fixed_mask(2'd0) >> 32)
		else $error("capability bits changed");
`endif

endmodule
